[hdl/rlhs_pkg.sv]
// Package: shared types, codes and the hop function for the link hop supervisor.
`timescale 1ns / 1ps

package rlhs_pkg;

    // Event kinds carried in the func field
    localparam logic [1:0] FUNC_RX_DONE    = 2'd0;
    localparam logic [1:0] FUNC_RX_TIMEOUT = 2'd1;
    localparam logic [1:0] FUNC_RESTART    = 2'd2;

    // Control frame source codes
    localparam logic [1:0] SRC_LIVE     = 2'd0;
    localparam logic [1:0] SRC_NONE     = 2'd1;
    localparam logic [1:0] SRC_FAILSAFE = 2'd2;

    // Loss policy codes
    localparam logic [1:0] POLICY_LIVE = 2'd0;
    localparam logic [1:0] POLICY_NONE = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_PARITY   = 2'd0;
    localparam logic [1:0] CFG_START_CHANNEL = 2'd1;
    localparam logic [1:0] CFG_LOSS_POLICY   = 2'd2;
    localparam logic [1:0] CFG_HOLD_LIMIT    = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] HOLD_LIMIT_RST = 8'd44;
    localparam logic [7:0] HOLD_MAX       = 8'd255;
    localparam logic [7:0] QUALITY_MAX    = 8'd200;

    localparam logic [8:0] HOP_ADD     = 9'd5;
    localparam logic [8:0] HOP_MOD     = 9'd101;
    localparam logic [8:0] HOP_MOD_X2  = 9'd202;
    localparam logic [6:0] CHANNEL_MAX = 7'd100;

    typedef struct packed {
        logic [1:0] func;
        logic       crc_error;
        logic       payload_received;
        logic       telemetry_bit;
        logic       button_pressed;
    } in_t;

    typedef struct packed {
        logic [6:0] channel;
        logic       iq_inverted;
        logic       linked;
        logic [7:0] link_quality;
        logic       send_telemetry;
        logic       bind_request;
        logic [1:0] frame_source;
    } out_t;

    typedef struct packed {
        logic       sync_parity;
        logic [6:0] start_channel;
        logic [1:0] loss_policy;
        logic [7:0] hold_limit;
    } cfg_t;

    // (2*ch + 5) mod 101; the sum stays below 303, so two compares suffice
    function automatic logic [6:0] hop_next(input logic [6:0] ch);
        logic [8:0] sum;
        logic [8:0] red;
        sum = {1'b0, ch, 1'b0} + HOP_ADD;
        if (sum >= HOP_MOD_X2)
            red = sum - HOP_MOD_X2;
        else if (sum >= HOP_MOD)
            red = sum - HOP_MOD;
        else
            red = sum;
        return red[6:0];
    endfunction

endpackage

[hdl/rlhs_cfg.sv]
// Configuration register file for the link hop supervisor.
`timescale 1ns / 1ps

module rlhs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rlhs_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [rlhs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rlhs_pkg::cfg_t                 cfg
);
    import rlhs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_SYNC_PARITY:   cfg_next.sync_parity   = cfg_wdata[0];
                CFG_START_CHANNEL: cfg_next.start_channel = cfg_wdata[6:0];
                CFG_LOSS_POLICY:   cfg_next.loss_policy   = cfg_wdata[1:0];
                CFG_HOLD_LIMIT:    cfg_next.hold_limit    = cfg_wdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_parity   <= 1'b0;
            cfg_reg.start_channel <= 7'd0;
            cfg_reg.loss_policy   <= POLICY_LIVE;
            cfg_reg.hold_limit    <= HOLD_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/rlhs_core.sv]
// Link state registers and the per-event update logic.
`timescale 1ns / 1ps

module rlhs_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  rlhs_pkg::in_t   item,
    input  rlhs_pkg::cfg_t  cfg,
    output rlhs_pkg::out_t  result
);
    import rlhs_pkg::*;

    logic [6:0] channel_reg, channel_next;
    logic       link_reg, link_next;
    logic       good_reg, good_next;
    logic [7:0] quality_reg, quality_next;
    logic [7:0] hold_reg, hold_next;
    logic       tele_reg, tele_next;

    logic       send_tel;
    logic       bind_req;
    logic [7:0] hold_inc;

    always_comb
    begin
        channel_next = channel_reg;
        link_next    = link_reg;
        good_next    = good_reg;
        quality_next = quality_reg;
        hold_next    = hold_reg;
        tele_next    = tele_reg;
        send_tel     = 1'b0;
        bind_req     = 1'b0;
        hold_inc     = hold_reg;

        // Event effect
        case (item.func)
            FUNC_RX_DONE:
            begin
                if (item.crc_error)
                    good_next = 1'b0;
                else
                begin
                    good_next = 1'b1;
                    link_next = 1'b1;
                    if (item.payload_received)
                        tele_next = item.telemetry_bit;
                end
                if (link_next)
                    channel_next = hop_next(channel_reg);
            end
            FUNC_RX_TIMEOUT:
            begin
                good_next = 1'b0;
                if (link_reg)
                    channel_next = hop_next(channel_reg);
            end
            FUNC_RESTART:
            begin
                channel_next = hop_next(cfg.start_channel);
                link_next    = 1'b0;
                good_next    = 1'b0;
                quality_next = 8'd0;
                hold_next    = 8'd0;
                tele_next    = 1'b0;
            end
            default: ;
        endcase

        // Bookkeeping: quality count, telemetry, link drop
        if (good_next)
        begin
            if (tele_next)
            begin
                send_tel  = 1'b1;
                tele_next = 1'b0;
            end
            if (quality_next < QUALITY_MAX)
                quality_next = quality_next + 8'd1;
        end
        else if (quality_next != 8'd0)
            quality_next = quality_next - 8'd1;

        if (quality_next == 8'd0)
            link_next = 1'b0;

        // Bind button hold counter, saturating at the top
        if (!link_next && item.button_pressed)
        begin
            hold_inc = (hold_next == HOLD_MAX) ? hold_next : hold_next + 8'd1;
            if (hold_inc > cfg.hold_limit)
            begin
                bind_req  = 1'b1;
                hold_next = 8'd0;
            end
            else
                hold_next = hold_inc;
        end
        else
            hold_next = 8'd0;

        result.channel        = channel_next;
        result.iq_inverted    = (cfg.sync_parity == channel_next[0]);
        result.linked         = link_next;
        result.link_quality   = quality_next;
        result.send_telemetry = send_tel;
        result.bind_request   = bind_req;
        if (link_next || cfg.loss_policy == POLICY_LIVE)
            result.frame_source = SRC_LIVE;
        else if (cfg.loss_policy == POLICY_NONE)
            result.frame_source = SRC_NONE;
        else
            result.frame_source = SRC_FAILSAFE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= 7'd0;
            link_reg    <= 1'b0;
            good_reg    <= 1'b0;
            quality_reg <= 8'd0;
            hold_reg    <= 8'd0;
            tele_reg    <= 1'b0;
        end
        else if (accept)
        begin
            channel_reg <= channel_next;
            link_reg    <= link_next;
            good_reg    <= good_next;
            quality_reg <= quality_next;
            hold_reg    <= hold_next;
            tele_reg    <= tele_next;
        end
    end

    // A linked state always carries a nonzero quality count
    a_link_has_quality: assert property (@(posedge clk) disable iff (!rst_n)
        link_reg |-> quality_reg != 8'd0)
        else $error("linked with zero quality count");

    // Quality count never leaves its range
    a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
        quality_reg <= QUALITY_MAX)
        else $error("quality count above maximum");

    // Hold count is only kept while unlinked
    a_hold_unlinked: assert property (@(posedge clk) disable iff (!rst_n)
        link_reg |-> hold_reg == 8'd0)
        else $error("hold count nonzero while linked");

endmodule

[hdl/rc_link_hop_supervisor.sv]
// Top level of the hopping receiver link supervisor.
`timescale 1ns / 1ps
//
// Usage: one radio event enters per in_data transaction (in_valid/in_ready):
// receive done, receive timeout or restart, plus the CRC, payload, telemetry
// and bind-button flags. Each event yields exactly one out_data transaction
// (out_valid/out_ready) with the hop channel, IQ inversion, link status,
// quality count, telemetry and bind requests and the control frame source.
// Output: the result is in the output register in the cycle after the event
// is accepted. Throughput: one event per cycle while out_ready keeps up; the
// link state registers update in the accept cycle, so the next event sees
// them right away. Stall: while out_ready is low and a result is held,
// in_ready drops and the held result stays put; in_ready rises again in the
// cycle the result is taken, so events flow without bubbles under a ready
// receiver. Configuration: cfg_we writes cfg_wdata to register cfg_idx (sync
// parity, start channel, loss policy, hold limit); write only while no
// transaction is in flight. Reset (rst_n low) clears the link state and the
// output valid flag, and restores hold limit 44 and the other registers to 0.
//
module rc_link_hop_supervisor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rlhs_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rlhs_pkg::out_t                  out_data,
    input  logic                            cfg_we,
    input  logic [rlhs_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rlhs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rlhs_pkg::*;

    cfg_t cfg;
    out_t result;
    logic accept;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;

    // Take a new event whenever the output slot is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    rlhs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rlhs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg),
        .result (result)
    );

    // Hold the result until taken; load a fresh one on each accept
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every accepted event produces a result in the next cycle
    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted event produced no result");

    // A linked result always forwards live frames
    a_linked_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.linked |-> out_data.frame_source == SRC_LIVE)
        else $error("linked result not on live source");

    // Bind requests only occur while unlinked
    a_bind_unlinked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bind_request |-> !out_data.linked)
        else $error("bind request while linked");

    // Hop channel stays within the band
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.channel <= CHANNEL_MAX)
        else $error("channel out of range");

endmodule
